// ===== src/si2dec_pkg.sv =====
// ----------------------------------------------------------------------------
// Signed integer to decimal ASCII: shared definitions
// Character codes and digit sizes used by the conversion block.
// ----------------------------------------------------------------------------
`default_nettype none

package si2dec_pkg;

  localparam int unsigned CHAR_W  = 6;
  localparam int unsigned DIGIT_W = 4;

  typedef logic [CHAR_W-1:0]  char_t;
  typedef logic [DIGIT_W-1:0] digit_t;

  localparam char_t  CHAR_MINUS = 6'd45;
  localparam char_t  CHAR_ZERO  = 6'd48;
  localparam digit_t DIGIT_FIVE = 4'd5;
  localparam digit_t DIGIT_NINE = 4'd9;
  localparam digit_t DAB_ADJUST = 4'd3;

endpackage

`default_nettype wire

// ===== src/signed_int_to_decimal_ascii_top.sv =====
// ----------------------------------------------------------------------------
// Signed integer to decimal ASCII converter
// Turns one signed integer into its decimal text, one ASCII character per
// output transaction, a minus sign first if negative, and no leading zeros.
// ----------------------------------------------------------------------------
//
//  Channel | Signals                                  | Direction
//  --------+------------------------------------------+----------
//  input   | in_valid, in_stall, value[63:0]          | in
//  output  | out_valid, out_stall, ascii_char[5:0], last | out
//
//  One input transaction goes through shift-and-add-3 conversion in a single
//  shared BCD unit, then has its leading zeros dropped, then is emitted one
//  character at a time while the output is free. Reset is synchronous and
//  returns the sequencer to idle with no output. A stalled output holds its
//  character; a new number is taken once the previous one has been fully
//  handed to the output register.

`default_nettype none

module signed_int_to_decimal_ascii_top #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [63:0] value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [5:0]              ascii_char,
  output logic                    last
);

  localparam int unsigned NDIG   = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
  localparam int unsigned BCD_W  = NDIG * si2dec_pkg::DIGIT_W;
  localparam int unsigned BCNT_W = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
  localparam int unsigned DCNT_W = $clog2(NDIG + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_SKIP = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]             state;
  logic [1:0]             state_next;
  logic [VALUE_WIDTH-1:0] mag;
  logic [VALUE_WIDTH-1:0] mag_next;
  logic [BCD_W-1:0]       bcd;
  logic [BCD_W-1:0]       bcd_next;
  logic [BCD_W-1:0]       bcd_adj;
  logic [BCNT_W-1:0]      bit_cnt;
  logic [BCNT_W-1:0]      bit_cnt_next;
  logic [DCNT_W-1:0]      dig_cnt;
  logic [DCNT_W-1:0]      dig_cnt_next;
  logic                   neg;
  logic                   neg_next;
  logic                   out_valid_next;
  si2dec_pkg::char_t      ascii_char_next;
  logic                   last_next;

  logic [VALUE_WIDTH-1:0] raw;
  logic                   in_take;
  logic                   out_free;
  si2dec_pkg::digit_t     top_digit;

  assign raw       = value[VALUE_WIDTH-1:0];
  assign in_stall  = (state != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign top_digit = bcd[BCD_W-1 -: si2dec_pkg::DIGIT_W];

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd[i*si2dec_pkg::DIGIT_W +: si2dec_pkg::DIGIT_W] >= si2dec_pkg::DIGIT_FIVE) begin
        bcd_adj[i*si2dec_pkg::DIGIT_W +: si2dec_pkg::DIGIT_W] =
          bcd[i*si2dec_pkg::DIGIT_W +: si2dec_pkg::DIGIT_W] + si2dec_pkg::DAB_ADJUST;
      end else begin
        bcd_adj[i*si2dec_pkg::DIGIT_W +: si2dec_pkg::DIGIT_W] =
          bcd[i*si2dec_pkg::DIGIT_W +: si2dec_pkg::DIGIT_W];
      end
    end
  end

  always_comb begin
    state_next      = state;
    mag_next        = mag;
    bcd_next        = bcd;
    bit_cnt_next    = bit_cnt;
    dig_cnt_next    = dig_cnt;
    neg_next        = neg;
    out_valid_next  = out_valid && out_stall;
    ascii_char_next = ascii_char;
    last_next       = last;
    case (state)
      ST_IDLE: begin
        if (in_take) begin
          neg_next     = raw[VALUE_WIDTH-1];
          mag_next     = raw[VALUE_WIDTH-1] ? (~raw + 1'b1) : raw;
          bcd_next     = '0;
          bit_cnt_next = BCNT_W'(VALUE_WIDTH - 1);
          dig_cnt_next = DCNT_W'(NDIG);
          state_next   = ST_CONV;
        end
      end
      ST_CONV: begin
        bcd_next = {bcd_adj[BCD_W-2:0], mag[VALUE_WIDTH-1]};
        mag_next = {mag[VALUE_WIDTH-2:0], 1'b0};
        if (bit_cnt == '0) begin
          state_next = ST_SKIP;
        end else begin
          bit_cnt_next = bit_cnt - 1'b1;
        end
      end
      ST_SKIP: begin
        if ((dig_cnt > DCNT_W'(1)) && (top_digit == '0)) begin
          bcd_next     = {bcd[BCD_W-si2dec_pkg::DIGIT_W-1:0], si2dec_pkg::DIGIT_W'(0)};
          dig_cnt_next = dig_cnt - 1'b1;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          if (neg) begin
            ascii_char_next = si2dec_pkg::CHAR_MINUS;
            last_next       = 1'b0;
            neg_next        = 1'b0;
          end else begin
            ascii_char_next = si2dec_pkg::CHAR_ZERO + si2dec_pkg::CHAR_W'(top_digit);
            last_next       = (dig_cnt == DCNT_W'(1));
            bcd_next        = {bcd[BCD_W-si2dec_pkg::DIGIT_W-1:0], si2dec_pkg::DIGIT_W'(0)};
            dig_cnt_next    = dig_cnt - 1'b1;
            if (dig_cnt == DCNT_W'(1)) begin
              state_next = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      neg       <= 1'b0;
      bit_cnt   <= '0;
      dig_cnt   <= '0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      neg       <= neg_next;
      bit_cnt   <= bit_cnt_next;
      dig_cnt   <= dig_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    mag        <= mag_next;
    bcd        <= bcd_next;
    ascii_char <= ascii_char_next;
    last       <= last_next;
  end

`ifndef ASSERT_OFF
  a_emit_digit_decimal: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (top_digit <= si2dec_pkg::DIGIT_NINE))
    else $error("Non-decimal digit reached the output stage.");

  a_skip_keeps_digit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SKIP || state == ST_EMIT) |-> (dig_cnt != '0))
    else $error("Digit count ran out before the final character.");

  a_char_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (ascii_char == si2dec_pkg::CHAR_MINUS ||
                   (ascii_char >= si2dec_pkg::CHAR_ZERO &&
                    ascii_char <= si2dec_pkg::CHAR_ZERO + 6'd9)))
    else $error("Output character is neither a digit nor a minus sign.");

  a_conv_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CONV) |=> (state == ST_CONV || state == ST_SKIP))
    else $error("Conversion left by an unexpected path.");
`endif

endmodule

`default_nettype wire
